[design/fisp_pkg.sv]
// Package: shared types and constants of the firmware image section parser.
package fisp_pkg;

  // Signature word as it appears after four little-endian bytes
  localparam logic [31:0] SIG_WORD  = 32'h5453_5324;
  localparam logic [31:0] RAM_INSTR = 32'd1;
  localparam logic [31:0] RAM_DATA  = 32'd2;

  // Image header length, counted into the declared size check
  localparam logic [32:0] IMAGE_HDR_BYTES = 33'd32;
  localparam logic [32:0] BYTE_TOTAL_MAX  = {33{1'b1}};

  // Byte positions of the last byte of each header field
  localparam logic [4:0] POS_WORD0   = 5'd3;
  localparam logic [4:0] POS_WORD1   = 5'd7;
  localparam logic [4:0] POS_WORD2   = 5'd11;
  localparam logic [4:0] POS_BLK_END = 5'd15;
  localparam logic [4:0] POS_ENTRY   = 5'd19;
  localparam logic [4:0] POS_PERSIST = 5'd23;
  localparam logic [4:0] POS_MOD_END = 5'd27;
  localparam logic [4:0] POS_IMG_END = 5'd31;

  // Result queue geometry
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_MODHDR  = 4'd1,
    PH_BLKHDR  = 4'd2,
    PH_PAYLOAD = 4'd3,
    PH_SKIP    = 4'd4,
    PH_DONE    = 4'd5,
    PH_DRAIN   = 4'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_MODULE  = 3'd0,
    KIND_SECTION = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_ACCEPT  = 3'd3,
    KIND_REJECT  = 3'd4
  } item_kind_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_SIGNATURE  = 3'd1,
    ERR_SIZE       = 3'd2,
    ERR_ZERO_BLOCK = 3'd3,
    ERR_RAM_TYPE   = 3'd4,
    ERR_OVERRUN    = 3'd5
  } error_e;

  typedef struct packed {
    logic [2:0]  item_kind;
    logic [31:0] module_number;
    logic        ram_select;
    logic [31:0] offset_value;
    logic [31:0] size_value;
    logic [31:0] scratch_value;
    logic [7:0]  write_byte;
    logic [2:0]  error_code;
    logic        last_item;
  } res_t;

  // Results produced by one accepted byte, in delivery order
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

endpackage

[design/fisp_in_if.sv]
// Interface: image byte request channel.
interface fisp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[design/fisp_out_if.sv]
// Interface: parser result request channel.
interface fisp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [31:0] module_number;
  logic        ram_select;
  logic [31:0] offset_value;
  logic [31:0] size_value;
  logic [31:0] scratch_value;
  logic [7:0]  write_byte;
  logic [2:0]  error_code;
  logic        last_item;

  modport source (
    output valid, output item_kind, output module_number, output ram_select,
    output offset_value, output size_value, output scratch_value,
    output write_byte, output error_code, output last_item, input ready
  );
  modport sink (
    input valid, input item_kind, input module_number, input ram_select,
    input offset_value, input size_value, input scratch_value,
    input write_byte, input error_code, input last_item, output ready
  );
endinterface

[design/fisp_parser_core.sv]
// Parser core: per-byte state update and result generation.
module fisp_parser_core import fisp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output push_t      push_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  fbc_q, fbc_d;
  logic [31:0] ws_q, ws_d;
  logic [31:0] declared_q, declared_d;
  logic [32:0] total_q, total_d;
  logic [31:0] mods_left_q, mods_left_d;
  logic [31:0] mod_idx_q, mod_idx_d;
  logic [31:0] mod_bytes_q, mod_bytes_d;
  logic [31:0] blocks_q, blocks_d;
  logic [31:0] entry_q, entry_d;
  logic [31:0] persist_q, persist_d;
  logic        ram_q, ram_d;
  logic [31:0] blk_bytes_q, blk_bytes_d;
  logic [31:0] blk_off_q, blk_off_d;
  logic [31:0] pay_idx_q, pay_idx_d;
  error_e      err_q, err_d;

  res_t        item_r;
  res_t        final_r;
  logic        has_item;

  // Next state and phase result for one byte
  always_comb begin
    logic        go_skip;
    logic        go_next;
    logic [32:0] want;
    error_e      code;

    phase_d     = phase_q;
    fbc_d       = fbc_q;
    declared_d  = declared_q;
    mods_left_d = mods_left_q;
    mod_idx_d   = mod_idx_q;
    mod_bytes_d = mod_bytes_q;
    blocks_d    = blocks_q;
    entry_d     = entry_q;
    persist_d   = persist_q;
    ram_d       = ram_q;
    blk_bytes_d = blk_bytes_q;
    blk_off_d   = blk_off_q;
    pay_idx_d   = pay_idx_q;
    err_d       = err_q;
    go_skip     = 1'b0;
    go_next     = 1'b0;
    has_item    = 1'b0;
    item_r      = '0;
    final_r     = '0;
    code        = ERR_NONE;
    want        = '0;

    ws_d    = {data_byte_i, ws_q[31:8]};
    total_d = (total_q != BYTE_TOTAL_MAX) ? total_q + 33'd1 : total_q;

    case (phase_q)
      PH_HEADER: begin
        if (fbc_q == POS_WORD0 && ws_d != SIG_WORD) begin
          err_d   = ERR_SIGNATURE;
          phase_d = PH_DRAIN;
        end else begin
          if (fbc_q == POS_WORD1) declared_d = ws_d;
          if (fbc_q == POS_WORD2) mods_left_d = ws_d;
          if (fbc_q == POS_IMG_END) begin
            fbc_d   = '0;
            phase_d = (mods_left_q != '0) ? PH_MODHDR : PH_DONE;
          end else begin
            fbc_d = fbc_q + 5'd1;
          end
        end
      end
      PH_MODHDR: begin
        if (fbc_q == POS_WORD1)   mod_bytes_d = ws_d;
        if (fbc_q == POS_WORD2)   blocks_d    = ws_d;
        if (fbc_q == POS_ENTRY)   entry_d     = ws_d;
        if (fbc_q == POS_PERSIST) persist_d   = ws_d;
        if (fbc_q == POS_MOD_END) begin
          has_item             = 1'b1;
          item_r.item_kind     = KIND_MODULE;
          item_r.module_number = mod_idx_q;
          item_r.offset_value  = entry_q;
          item_r.size_value    = persist_q;
          item_r.scratch_value = ws_d;
          fbc_d                = '0;
          if (blocks_q != '0) phase_d = PH_BLKHDR;
          else                go_skip = 1'b1;
        end else begin
          fbc_d = fbc_q + 5'd1;
        end
      end
      PH_BLKHDR: begin
        if (mod_bytes_q == '0) begin
          err_d   = ERR_OVERRUN;
          phase_d = PH_DRAIN;
        end else begin
          mod_bytes_d = mod_bytes_q - 32'd1;
          if (fbc_q == POS_WORD0) blk_off_d = ws_d;
          if (fbc_q == POS_WORD1) begin
            blk_bytes_d = ws_d;
            ram_d       = (blk_off_q == RAM_DATA);
            if (ws_d == '0) begin
              err_d = ERR_ZERO_BLOCK;
            end else if (blk_off_q != RAM_INSTR && blk_off_q != RAM_DATA) begin
              err_d = ERR_RAM_TYPE;
            end
          end
          if (fbc_q == POS_WORD2) blk_off_d = ws_d;
          if (fbc_q == POS_BLK_END) begin
            has_item             = 1'b1;
            item_r.item_kind     = KIND_SECTION;
            item_r.module_number = mod_idx_q;
            item_r.ram_select    = ram_q;
            item_r.offset_value  = blk_off_q;
            item_r.size_value    = blk_bytes_q;
            item_r.error_code    = err_q;
            fbc_d                = '0;
            if (err_q != ERR_NONE) begin
              phase_d = PH_DRAIN;
            end else begin
              pay_idx_d = '0;
              phase_d   = PH_PAYLOAD;
            end
          end else begin
            fbc_d = fbc_q + 5'd1;
          end
        end
      end
      PH_PAYLOAD: begin
        if (mod_bytes_q == '0) begin
          err_d   = ERR_OVERRUN;
          phase_d = PH_DRAIN;
        end else begin
          mod_bytes_d          = mod_bytes_q - 32'd1;
          has_item             = 1'b1;
          item_r.item_kind     = KIND_WRITE;
          item_r.module_number = mod_idx_q;
          item_r.ram_select    = ram_q;
          item_r.offset_value  = blk_off_q + pay_idx_q;
          item_r.write_byte    = data_byte_i;
          pay_idx_d            = pay_idx_q + 32'd1;
          blk_bytes_d          = blk_bytes_q - 32'd1;
          if (blk_bytes_d == '0) begin
            blocks_d = blocks_q - 32'd1;
            fbc_d    = '0;
            if (blocks_d != '0) phase_d = PH_BLKHDR;
            else                go_skip = 1'b1;
          end
        end
      end
      PH_SKIP: begin
        if (mod_bytes_q != '0) mod_bytes_d = mod_bytes_q - 32'd1;
        if (mod_bytes_d == '0) go_next = 1'b1;
      end
      default: ;
    endcase

    // Skip the unused rest of a module, or move on at once
    if (go_skip) begin
      if (mod_bytes_d == '0) go_next = 1'b1;
      else                   phase_d = PH_SKIP;
    end

    // Advance to the next module header
    if (go_next) begin
      mod_idx_d   = mod_idx_q + 32'd1;
      mods_left_d = mods_left_q - 32'd1;
      fbc_d       = '0;
      phase_d     = (mods_left_d != '0) ? PH_MODHDR : PH_DONE;
    end

    item_r.last_item = !last_byte_i;

    // Final verdict on the marked last byte, then back to reset state
    if (last_byte_i) begin
      want = {1'b0, declared_d} + IMAGE_HDR_BYTES;
      if (err_d == ERR_SIGNATURE)  code = ERR_SIGNATURE;
      else if (total_d != want)    code = ERR_SIZE;
      else if (err_d != ERR_NONE)  code = err_d;
      else if (phase_d != PH_DONE) code = ERR_OVERRUN;
      else                         code = ERR_NONE;
      final_r.item_kind  = (code != ERR_NONE) ? KIND_REJECT : KIND_ACCEPT;
      final_r.error_code = code;
      final_r.last_item  = 1'b1;

      phase_d     = PH_HEADER;
      fbc_d       = '0;
      ws_d        = '0;
      declared_d  = '0;
      total_d     = '0;
      mods_left_d = '0;
      mod_idx_d   = '0;
      mod_bytes_d = '0;
      blocks_d    = '0;
      entry_d     = '0;
      persist_d   = '0;
      ram_d       = 1'b0;
      blk_bytes_d = '0;
      blk_off_d   = '0;
      pay_idx_d   = '0;
      err_d       = ERR_NONE;
    end
  end

  // Results handed to the queue for this byte
  always_comb begin
    push_o.count  = accept_i ? ({1'b0, has_item} + {1'b0, last_byte_i}) : 2'd0;
    push_o.first  = has_item ? item_r : final_r;
    push_o.second = final_r;
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      fbc_q       <= '0;
      ws_q        <= '0;
      declared_q  <= '0;
      total_q     <= '0;
      mods_left_q <= '0;
      mod_idx_q   <= '0;
      mod_bytes_q <= '0;
      blocks_q    <= '0;
      entry_q     <= '0;
      persist_q   <= '0;
      ram_q       <= 1'b0;
      blk_bytes_q <= '0;
      blk_off_q   <= '0;
      pay_idx_q   <= '0;
      err_q       <= ERR_NONE;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      fbc_q       <= fbc_d;
      ws_q        <= ws_d;
      declared_q  <= declared_d;
      total_q     <= total_d;
      mods_left_q <= mods_left_d;
      mod_idx_q   <= mod_idx_d;
      mod_bytes_q <= mod_bytes_d;
      blocks_q    <= blocks_d;
      entry_q     <= entry_d;
      persist_q   <= persist_d;
      ram_q       <= ram_d;
      blk_bytes_q <= blk_bytes_d;
      blk_off_q   <= blk_off_d;
      pay_idx_q   <= pay_idx_d;
      err_q       <= err_d;
    end
  end

  // The last byte always returns the parser to the header phase
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> phase_q == PH_HEADER && err_q == ERR_NONE)
    else $error("parser state not cleared after last byte");

  // A byte with two results always ends with the verdict
  a_pair_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.count == 2'd2 |->
      (push_o.second.item_kind == KIND_ACCEPT || push_o.second.item_kind == KIND_REJECT))
    else $error("second result of a byte is not a verdict");

endmodule

[design/fisp_result_fifo.sv]
// Result queue: two results in per cycle at most, one out per ready cycle.
module fisp_result_fifo import fisp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  space_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  data_o
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [FIFO_PTR_W-1:0] wp_inc;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic                  pop;

  // Room for the worst case of two results from one byte
  assign space_o = count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2);
  assign valid_o = count_q != '0;
  assign data_o  = mem[rp_q];
  assign pop     = valid_o && ready_i;
  assign wp_inc  = wp_q + FIFO_PTR_W'(1);

  // Pointer and fill count update
  always_comb begin
    wp_d    = wp_q + FIFO_PTR_W'(push_i.count);
    rp_d    = pop ? rp_q + FIFO_PTR_W'(1) : rp_q;
    count_d = count_q + FIFO_CNT_W'(push_i.count) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      count_q <= '0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      count_q <= count_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem[wp_q] <= push_i.first;
    if (push_i.count == 2'd2) mem[wp_inc] <= push_i.second;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.count != 2'd0 |-> space_o)
    else $error("results pushed without room");

endmodule

[design/firmware_image_section_parser_unit.sv]
// Top level: firmware image section parser with byte input and result output.
//
//   channel  dir  modport  payload
//   in_i     in   sink     data_byte, last_byte
//   res_o    out  source   item_kind .. last_item (module/section/write/verdict)
//
// One image byte is accepted per cycle while in_i.ready is high; its state
// update is registered. A byte yields zero, one or two results; the result
// queue (four entries) delivers one per cycle while res_o.ready is high.
// in_i.ready drops while the queue has fewer than two free entries.
// Reset (rst_ni low, asynchronous) returns the parser to the header phase.
module firmware_image_section_parser_unit import fisp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fisp_in_if.sink     in_i,
  fisp_out_if.source  res_o
);

  push_t push;
  res_t  head;
  logic  accept;

  assign accept = in_i.valid && in_i.ready;

  fisp_parser_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (in_i.data_byte),
    .last_byte_i (in_i.last_byte),
    .push_o      (push)
  );

  fisp_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (in_i.ready),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (head)
  );

  // Result fields onto the output channel
  assign res_o.item_kind     = head.item_kind;
  assign res_o.module_number = head.module_number;
  assign res_o.ram_select    = head.ram_select;
  assign res_o.offset_value  = head.offset_value;
  assign res_o.size_value    = head.size_value;
  assign res_o.scratch_value = head.scratch_value;
  assign res_o.write_byte    = head.write_byte;
  assign res_o.error_code    = head.error_code;
  assign res_o.last_item     = head.last_item;

endmodule

[tb/tb.sv]
// Testbench for the firmware image section parser: directed and random images, scored in order.
`timescale 1ns / 100ps

module tb;
  import fisp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;

  fisp_in_if  in_if ();
  fisp_out_if res_if ();

  firmware_image_section_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if)
  );

  always #10 clk_i = ~clk_i;

  // Predicted results, oldest first
  res_t expected_items[$];
  res_t want_item;
  int   mismatch_count = 0;

  // Bytes accepted by the block so far
  int   bytes_sent = 0;

  // Idling controls for sender and receiver
  bit tx_random = 1'b0;
  bit rx_random = 1'b0;
  int rx_hold   = 0;

  // Image under construction
  logic [7:0] img_q[$];
  int mod_start;
  int mod_size_pos;

  // Parser state as predicted
  phase_e      ph;
  logic [4:0]  fpos;
  logic [31:0] shift_word;
  logic [31:0] decl_size;
  logic [32:0] bytes_seen;
  logic [31:0] mods_to_go;
  logic [31:0] mod_idx;
  logic [31:0] mod_left;
  logic [31:0] blks_to_go;
  logic [31:0] entry_w;
  logic [31:0] persist_w;
  logic        blk_dram;
  logic [31:0] blk_left;
  logic [31:0] blk_off;
  logic [31:0] pay_idx;
  error_e      err_seen;

  // ---------------------------------------------------------------- predictor

  task automatic parser_clear();
    ph         = PH_HEADER;
    fpos       = '0;
    shift_word = '0;
    decl_size  = '0;
    bytes_seen = '0;
    mods_to_go = '0;
    mod_idx    = '0;
    mod_left   = '0;
    blks_to_go = '0;
    entry_w    = '0;
    persist_w  = '0;
    blk_dram   = 1'b0;
    blk_left   = '0;
    blk_off    = '0;
    pay_idx    = '0;
    err_seen   = ERR_NONE;
  endtask

  function automatic res_t make_res(input item_kind_e kind, input logic [31:0] mod,
                                    input logic ram, input logic [31:0] off,
                                    input logic [31:0] size, input logic [31:0] scratch,
                                    input logic [7:0] wb, input error_e err);
    res_t r;
    r.item_kind     = kind;
    r.module_number = mod;
    r.ram_select    = ram;
    r.offset_value  = off;
    r.size_value    = size;
    r.scratch_value = scratch;
    r.write_byte    = wb;
    r.error_code    = err;
    r.last_item     = 1'b0;
    return r;
  endfunction

  task automatic next_module();
    mod_idx++;
    mods_to_go--;
    fpos = '0;
    ph = (mods_to_go != 0) ? PH_MODHDR : PH_DONE;
  endtask

  task automatic begin_skip();
    if (mod_left == 0) next_module();
    else ph = PH_SKIP;
  endtask

  // Advance the predicted parser by one byte and queue what it yields
  task automatic parse_byte(input logic [7:0] b, input logic lastb);
    res_t        outs[2];
    int          n;
    logic [4:0]  pos;
    logic [32:0] want;
    error_e      code;
    n   = 0;
    pos = fpos;
    if (bytes_seen != BYTE_TOTAL_MAX) bytes_seen++;
    shift_word = {b, shift_word[31:8]};

    case (ph)
      PH_HEADER: begin
        if (pos == POS_WORD0 && shift_word != SIG_WORD) begin
          err_seen = ERR_SIGNATURE;
          ph = PH_DRAIN;
        end else begin
          if (pos == POS_WORD1) decl_size = shift_word;
          if (pos == POS_WORD2) mods_to_go = shift_word;
          if (pos == POS_IMG_END) begin
            fpos = '0;
            ph = (mods_to_go != 0) ? PH_MODHDR : PH_DONE;
          end else begin
            fpos++;
          end
        end
      end
      PH_MODHDR: begin
        if (pos == POS_WORD1) mod_left = shift_word;
        if (pos == POS_WORD2) blks_to_go = shift_word;
        if (pos == POS_ENTRY) entry_w = shift_word;
        if (pos == POS_PERSIST) persist_w = shift_word;
        if (pos == POS_MOD_END) begin
          outs[n] = make_res(KIND_MODULE, mod_idx, 1'b0, entry_w, persist_w, shift_word,
                             8'h00, ERR_NONE);
          n++;
          fpos = '0;
          if (blks_to_go != 0) ph = PH_BLKHDR;
          else begin_skip();
        end else begin
          fpos++;
        end
      end
      PH_BLKHDR: begin
        if (mod_left == 0) begin
          err_seen = ERR_OVERRUN;
          ph = PH_DRAIN;
        end else begin
          mod_left--;
          if (pos == POS_WORD0) blk_off = shift_word;
          if (pos == POS_WORD1) begin
            blk_left = shift_word;
            blk_dram = (blk_off == RAM_DATA);
            if (shift_word == 0) err_seen = ERR_ZERO_BLOCK;
            else if (blk_off != RAM_INSTR && blk_off != RAM_DATA) err_seen = ERR_RAM_TYPE;
          end
          if (pos == POS_WORD2) blk_off = shift_word;
          if (pos == POS_BLK_END) begin
            outs[n] = make_res(KIND_SECTION, mod_idx, blk_dram, blk_off, blk_left, '0,
                               8'h00, err_seen);
            n++;
            fpos = '0;
            if (err_seen != ERR_NONE) begin
              ph = PH_DRAIN;
            end else begin
              pay_idx = '0;
              ph = PH_PAYLOAD;
            end
          end else begin
            fpos++;
          end
        end
      end
      PH_PAYLOAD: begin
        if (mod_left == 0) begin
          err_seen = ERR_OVERRUN;
          ph = PH_DRAIN;
        end else begin
          mod_left--;
          outs[n] = make_res(KIND_WRITE, mod_idx, blk_dram, blk_off + pay_idx, '0, '0,
                             b, ERR_NONE);
          n++;
          pay_idx++;
          blk_left--;
          if (blk_left == 0) begin
            blks_to_go--;
            fpos = '0;
            if (blks_to_go != 0) ph = PH_BLKHDR;
            else begin_skip();
          end
        end
      end
      PH_SKIP: begin
        if (mod_left != 0) mod_left--;
        if (mod_left == 0) next_module();
      end
      default: ;
    endcase

    // Verdict on the final byte, then back to the reset state
    if (lastb) begin
      want = {1'b0, decl_size} + IMAGE_HDR_BYTES;
      if (err_seen == ERR_SIGNATURE) code = ERR_SIGNATURE;
      else if (bytes_seen != want) code = ERR_SIZE;
      else if (err_seen != ERR_NONE) code = err_seen;
      else if (ph != PH_DONE) code = ERR_OVERRUN;
      else code = ERR_NONE;
      outs[n] = make_res((code != ERR_NONE) ? KIND_REJECT : KIND_ACCEPT, '0, 1'b0, '0, '0,
                         '0, 8'h00, code);
      n++;
      parser_clear();
    end

    if (n > 0) outs[n-1].last_item = 1'b1;
    for (int i = 0; i < n; i++) expected_items.push_back(outs[i]);
  endtask

  // ---------------------------------------------------------------- checker

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_items.size() == 0) begin
        $error("result with no prediction pending: kind %0d", res_if.item_kind);
        mismatch_count++;
      end else begin
        want_item = expected_items.pop_front();
        check_field("item_kind", 32'(want_item.item_kind), 32'(res_if.item_kind));
        check_field("module_number", want_item.module_number, res_if.module_number);
        check_field("ram_select", 32'(want_item.ram_select), 32'(res_if.ram_select));
        check_field("offset_value", want_item.offset_value, res_if.offset_value);
        check_field("size_value", want_item.size_value, res_if.size_value);
        check_field("scratch_value", want_item.scratch_value, res_if.scratch_value);
        check_field("write_byte", 32'(want_item.write_byte), 32'(res_if.write_byte));
        check_field("error_code", 32'(want_item.error_code), 32'(res_if.error_code));
        check_field("last_item", 32'(want_item.last_item), 32'(res_if.last_item));
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // Ready is set on a falling edge and kept through any gap; a long hold is counted here
  initial begin
    int n;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        n = rx_hold;
        rx_hold = 0;
        res_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk_i);
      end else if (rx_random && $urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b0;
        repeat (gap_len() - 1) @(negedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- sender

  // Offer one byte from a falling edge and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic lastb);
    int gap;
    gap = (tx_random && $urandom_range(0, 3) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.last_byte <= lastb;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    parse_byte(b, lastb);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and let every predicted result drain
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_items.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_idling(input bit on);
    tx_random = on;
    rx_random = on;
  endtask

  // ---------------------------------------------------------------- image builder

  task automatic push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) img_q.push_back(w[8*k +: 8]);
  endtask

  task automatic patch_word(input int pos, input logic [31:0] w);
    for (int k = 0; k < 4; k++) img_q[pos + k] = w[8*k +: 8];
  endtask

  task automatic img_header(input logic [31:0] nmods);
    push_word(SIG_WORD);
    push_word('0);
    push_word(nmods);
    repeat (5) push_word($urandom);
  endtask

  task automatic img_module(input logic [31:0] nblk, input logic [31:0] entry,
                            input logic [31:0] persist, input logic [31:0] scratch);
    push_word($urandom);
    mod_size_pos = img_q.size();
    push_word('0);
    push_word(nblk);
    push_word($urandom);
    push_word(entry);
    push_word(persist);
    push_word(scratch);
    mod_start = img_q.size();
  endtask

  task automatic img_block(input logic [31:0] rtype, input logic [31:0] size,
                           input logic [31:0] off, input int npay);
    push_word(rtype);
    push_word(size);
    push_word(off);
    push_word($urandom);
    repeat (npay) img_q.push_back(8'($urandom));
  endtask

  // Pad the module and fill in its size; adjust < 0 makes it too short
  task automatic img_module_end(input int pad, input int adjust);
    repeat (pad) img_q.push_back(8'($urandom));
    patch_word(mod_size_pos, 32'(img_q.size() - mod_start + adjust));
  endtask

  // Fill in the declared size, optionally cut the tail, and send the image
  task automatic img_send(input int size_adj, input int drop);
    if (img_q.size() >= 8) patch_word(4, 32'(img_q.size() - 32 + size_adj));
    repeat (drop) if (img_q.size() > 1) void'(img_q.pop_back());
    for (int i = 0; i < img_q.size(); i++) send_byte(img_q[i], i == img_q.size() - 1);
    img_q.delete();
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_bad_signature();
    img_header(1);
    img_q[3] = 8'hFF;
    img_send(0, 22);
    img_header(0);
    img_q[0] = 8'h00;
    img_send(0, 0);
    // single byte image: too short, size mismatch
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_empty_image();
    img_header(0);
    img_send(0, 0);
    // huge module count, nothing after the header
    img_header(32'hFFFF_FFFF);
    img_send(0, 0);
  endtask

  task automatic test_sections();
    // instruction and data blocks, write address wraps; ends on a payload byte
    img_header(1);
    img_module(2, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
    img_block(RAM_INSTR, 3, 32'h0, 3);
    img_block(RAM_DATA, 2, 32'hFFFF_FFFF, 2);
    img_module_end(0, 0);
    img_send(0, 0);
    // modules with no blocks; the last byte closes a module header
    img_header(2);
    img_module(0, $urandom, $urandom, $urandom);
    img_module_end(3, 0);
    img_module(0, $urandom, $urandom, $urandom);
    img_module_end(0, 0);
    img_send(0, 0);
  endtask

  task automatic test_rejected_blocks();
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_DATA, 0, $urandom, 0);
    img_module_end(2, 0);
    img_send(0, 0);
    foreach (img_q[i]) ;
    img_header(1);
    img_module(2, $urandom, $urandom, $urandom);
    img_block(RAM_INSTR, 1, $urandom, 1);
    img_block(32'h0, 4, $urandom, 4);
    img_module_end(0, 0);
    img_send(0, 0);
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, $urandom, 2);
    img_module_end(0, 0);
    img_send(0, 0);
  endtask

  task automatic test_overrun();
    // runs out of module bytes inside the payload
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_INSTR, 4, $urandom, 4);
    img_module_end(0, -3);
    img_send(0, 0);
    // runs out inside a block header
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_DATA, 4, $urandom, 4);
    img_module_end(0, -14);
    img_send(0, 0);
  endtask

  task automatic test_size_mismatch();
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_INSTR, 2, $urandom, 2);
    img_module_end(1, 0);
    img_send(1, 0);
    img_header(0);
    img_send(-1, 0);
    // trailing bytes counted in the declared size are accepted
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_DATA, 1, $urandom, 1);
    img_module_end(0, 0);
    repeat (3) img_q.push_back(8'($urandom));
    img_send(0, 0);
  endtask

  task automatic test_truncated();
    img_header(2);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_INSTR, 2, $urandom, 2);
    img_module_end(0, 0);
    img_send(0, 0);
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_DATA, 3, $urandom, 3);
    img_module_end(2, 0);
    img_send(0, 5);
  endtask

  // Receiver holds off while a long block streams in
  task automatic test_backpressure();
    set_idling(1'b0);
    rx_hold = 300;
    img_header(1);
    img_module(1, $urandom, $urandom, $urandom);
    img_block(RAM_DATA, 48, $urandom, 48);
    img_module_end(0, 0);
    img_send(0, 0);
    wait_idle();
  endtask

  task automatic test_random_images();
    int nmods, nblk, roll, mutation, bsize, nbytes;
    logic [31:0] btype, boff;
    while (bytes_sent < 1300) begin
      mutation = $urandom_range(0, 9);
      set_idling($urandom_range(0, 3) != 0);
      if (mutation == 9) begin
        // raw noise
        nbytes = $urandom_range(1, 40);
        for (int i = 0; i < nbytes; i++) send_byte(8'($urandom), i == nbytes - 1);
      end else begin
        nmods = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        img_header((mutation == 8) ? nmods + 1 : nmods);
        for (int m = 0; m < nmods; m++) begin
          nblk = $urandom_range(0, 3);
          img_module(nblk, $urandom, $urandom, $urandom);
          for (int k = 0; k < nblk; k++) begin
            roll  = $urandom_range(0, 15);
            bsize = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
            btype = 32'($urandom_range(RAM_INSTR, RAM_DATA));
            if (roll == 0) bsize = 0;
            if (roll == 1) btype = $urandom;
            boff = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                                : $urandom;
            img_block(btype, bsize, boff, bsize);
          end
          img_module_end($urandom_range(0, 3),
                         ($urandom_range(0, 9) == 0) ? -$urandom_range(1, 10) : 0);
        end
        if (mutation == 5) img_q[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));
        if (mutation == 4) repeat ($urandom_range(1, 5)) img_q.push_back(8'($urandom));
        img_send((mutation == 6) ? ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(1, 4) : 0,
                 (mutation == 7) ? $urandom_range(1, 20) : 0);
      end
      if ($urandom_range(0, 7) == 0) wait_idle();
    end
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    parser_clear();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    set_idling(1'b1);
    test_bad_signature();
    test_empty_image();
    test_sections();
    wait_idle();
    test_rejected_blocks();
    test_overrun();
    test_size_mismatch();
    test_truncated();
    wait_idle();
    test_backpressure();
    test_random_images();

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && expected_items.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

[sim.f]
design/fisp_pkg.sv
design/fisp_in_if.sv
design/fisp_out_if.sv
design/fisp_parser_core.sv
design/fisp_result_fifo.sv
design/firmware_image_section_parser_unit.sv
tb/tb.sv
